// ===== hw/rtl/nms_pkg.sv =====
// Package for the neighbour mean smoothing filter: widths, codes, item structs
// and the frame size clamp. No dependencies; every other RTL file uses it.
`default_nettype none

package nms_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned IDX_W    = $clog2(MAX_COLS);
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned MEAN_W   = 24;
  // sum of eight samples
  localparam int unsigned SUM_W    = SAMPLE_W + 3;
  localparam int unsigned MULT_W   = 32;
  localparam int unsigned PROD_W   = SUM_W + MULT_W;

  // reciprocal multipliers: quotient = (|sum| * MULT) >> SHIFT equals |sum| * 256 / n
  localparam logic [MULT_W-1:0] MULT_DIV3 = 32'hAAAA_AAAB;
  localparam logic [MULT_W-1:0] MULT_DIV5 = 32'hCCCC_CCCD;
  localparam logic [MULT_W-1:0] MULT_DIV8 = 32'h4000_0000;
  localparam int unsigned SHIFT_DIV3 = 25;
  localparam int unsigned SHIFT_DIV5 = 26;
  localparam int unsigned SHIFT_DIV8 = 25;

  localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};

  typedef enum logic [0:0] {
    CFG_FRAME_ROWS = 1'b0,
    CFG_FRAME_COLS = 1'b1
  } cfg_reg_e;

  // neighbour count: 3 at corners, 5 on edges, 8 inside
  typedef enum logic [1:0] {
    DIV3,
    DIV5,
    DIV8
  } div_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           idx_t;

  typedef struct packed {
    sample_t sample;
    sample_t above2;
    sample_t above1;
    idx_t    row;
    idx_t    col;
  } item_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
    logic run_last;
    logic frame_done;
  } tag_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    div_e                    div;
    tag_t                    tag;
  } emit_t;

  // Clamp a frame size to [2, vmax] and return its last index.
  function automatic idx_t size_last(input logic [CFG_W-1:0] v, input logic [CFG_W-1:0] vmax);
    logic [CFG_W-1:0] c;
    begin
      if (v < CFG_W'(2)) begin
        c = CFG_W'(2);
      end else if (v > vmax) begin
        c = vmax;
      end else begin
        c = v;
      end
      size_last = IDX_W'(c - CFG_W'(1));
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nms_if.sv =====
// Channel interfaces of the neighbour mean smoothing filter: sample in, result out.
// Depends on nms_pkg for the field types.
`default_nettype none

interface nms_sample_if;
  logic              valid;
  logic              ready;
  nms_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface nms_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [nms_pkg::MEAN_W-1:0]     mean_value;
  nms_pkg::idx_t                         out_row;
  nms_pkg::idx_t                         out_col;
  logic                                  run_last;
  logic                                  frame_done;

  modport source (output valid, output mean_value, output out_row, output out_col,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input mean_value, input out_row, input out_col,
                  input run_last, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nms_line_store.sv =====
// Two line stores of the filter, one bank per row parity, read at one column.
// Depends on nms_pkg for widths and depth.
`default_nettype none

module nms_line_store (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire nms_pkg::idx_t    addr_i,
  input  wire logic             wr_bank_i,
  input  wire nms_pkg::sample_t wr_data_i,
  output nms_pkg::sample_t      rd0_o,
  output nms_pkg::sample_t      rd1_o
);

  nms_pkg::sample_t bank0_mem [nms_pkg::MAX_COLS];
  nms_pkg::sample_t bank1_mem [nms_pkg::MAX_COLS];
  nms_pkg::sample_t rd0_q;
  nms_pkg::sample_t rd1_q;

  // read returns the value held before this write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd0_q <= bank0_mem[addr_i];
      if (!wr_bank_i) begin
        bank0_mem[addr_i] <= wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd1_q <= bank1_mem[addr_i];
      if (wr_bank_i) begin
        bank1_mem[addr_i] <= wr_data_i;
      end
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nms_window.sv =====
// 3x3 window and release sequencer: shifts one column per item, then hands out
// released elements as neighbour sums, one per ready cycle. Depends on nms_pkg.
`default_nettype none

module nms_window (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire nms_pkg::item_t item_i,
  output logic                item_ready_o,
  input  wire nms_pkg::idx_t  rows_last_i,
  input  wire nms_pkg::idx_t  cols_last_i,
  output logic                emit_valid_o,
  output nms_pkg::emit_t      emit_o,
  input  wire logic           emit_ready_i
);

  nms_pkg::sample_t win_q [3][3];
  logic [3:0]       mask_q;
  logic [3:0]       mask_d;
  nms_pkg::idx_t    row_q;
  nms_pkg::idx_t    col_q;

  logic [1:0]                       sel;
  logic [3:0]                       mask_rest;
  logic                             fire;
  logic                             item_fire;
  nms_pkg::idx_t                    orow;
  nms_pkg::idx_t                    ocol;
  logic [2:0]                       row_ok;
  logic [2:0]                       col_ok;
  logic [1:0]                       wr_idx;
  logic [1:0]                       wc_idx;
  logic signed [nms_pkg::SUM_W-1:0] sum;
  logic                             row_full;
  logic                             col_full;

  always_comb begin
    if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    mask_rest    = mask_q & (mask_q - 4'd1);
    emit_valid_o = |mask_q;
    fire         = emit_valid_o && emit_ready_i;
    item_ready_o = !emit_valid_o || (fire && (mask_rest == 4'd0));
    item_fire    = item_valid_i && item_ready_o;

    orow = sel[1] ? row_q : row_q - nms_pkg::IDX_W'(1);
    ocol = sel[0] ? col_q : col_q - nms_pkg::IDX_W'(1);

    row_ok = {orow != rows_last_i, 1'b1, orow != '0};
    col_ok = {ocol != cols_last_i, 1'b1, ocol != '0};

    // centre sits at window row 1 + sel[1], column 1 + sel[0]
    sum = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        wr_idx = 2'(dr) + {1'b0, sel[1]};
        wc_idx = 2'(dc) + {1'b0, sel[0]};
        if (!(dr == 1 && dc == 1) && row_ok[dr] && col_ok[dc]
            && (wr_idx != 2'd3) && (wc_idx != 2'd3)) begin
          sum = sum + nms_pkg::SUM_W'(win_q[wr_idx][wc_idx]);
        end
      end
    end

    row_full = row_ok[0] && row_ok[2];
    col_full = col_ok[0] && col_ok[2];

    emit_o.sum = sum;
    if (row_full && col_full) begin
      emit_o.div = nms_pkg::DIV8;
    end else if (row_full || col_full) begin
      emit_o.div = nms_pkg::DIV5;
    end else begin
      emit_o.div = nms_pkg::DIV3;
    end
    emit_o.tag.row        = orow;
    emit_o.tag.col        = ocol;
    emit_o.tag.run_last   = (mask_rest == 4'd0);
    emit_o.tag.frame_done = (orow == rows_last_i) && (ocol == cols_last_i);

    mask_d = mask_q;
    if (item_fire) begin
      mask_d[0] = (item_i.row != '0) && (item_i.col != '0);
      mask_d[1] = (item_i.row != '0) && (item_i.col == cols_last_i);
      mask_d[2] = (item_i.row == rows_last_i) && (item_i.col != '0);
      mask_d[3] = (item_i.row == rows_last_i) && (item_i.col == cols_last_i);
    end else if (fire) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= item_i.above2;
      win_q[1][2] <= item_i.above1;
      win_q[2][2] <= item_i.sample;
      row_q       <= item_i.row;
      col_q       <= item_i.col;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nms_mean.sv =====
// Mean pipeline: sum register, magnitude, reciprocal multiply, signed result
// register driving the result channel. Depends on nms_pkg and nms_result_if.
`default_nettype none

module nms_mean (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           emit_valid_i,
  input  wire nms_pkg::emit_t emit_i,
  output logic                emit_ready_o,
  nms_result_if.source        result_o
);

  logic                                c_valid_q;
  logic signed [nms_pkg::SUM_W-1:0]    c_sum_q;
  nms_pkg::div_e                       c_div_q;
  nms_pkg::tag_t                       c_tag_q;

  logic                                d_valid_q;
  logic [nms_pkg::SUM_W-1:0]           d_abs_q;
  logic                                d_neg_q;
  nms_pkg::div_e                       d_div_q;
  nms_pkg::tag_t                       d_tag_q;

  logic                                p_valid_q;
  logic [nms_pkg::PROD_W-1:0]          p_prod_q;
  logic                                p_neg_q;
  nms_pkg::div_e                       p_div_q;
  nms_pkg::tag_t                       p_tag_q;

  logic                                o_valid_q;
  logic signed [nms_pkg::MEAN_W-1:0]   o_mean_q;
  nms_pkg::tag_t                       o_tag_q;

  logic                                c_ready;
  logic                                d_ready;
  logic                                p_ready;
  logic                                o_ready;
  logic [nms_pkg::SUM_W-1:0]           abs_d;
  logic [nms_pkg::MULT_W-1:0]          mult;
  logic [nms_pkg::PROD_W-1:0]          prod_d;
  logic [nms_pkg::MEAN_W-1:0]          quot;
  logic signed [nms_pkg::MEAN_W-1:0]   mean_d;

  assign o_ready      = !o_valid_q || result_o.ready;
  assign p_ready      = !p_valid_q || o_ready;
  assign d_ready      = !d_valid_q || p_ready;
  assign c_ready      = !c_valid_q || d_ready;
  assign emit_ready_o = c_ready;

  always_comb begin
    abs_d = c_sum_q[nms_pkg::SUM_W-1] ? nms_pkg::SUM_W'(-c_sum_q) : nms_pkg::SUM_W'(c_sum_q);

    case (d_div_q)
      nms_pkg::DIV3: mult = nms_pkg::MULT_DIV3;
      nms_pkg::DIV5: mult = nms_pkg::MULT_DIV5;
      nms_pkg::DIV8: mult = nms_pkg::MULT_DIV8;
      default:       mult = nms_pkg::MULT_DIV8;
    endcase
    prod_d = {{nms_pkg::MULT_W{1'b0}}, d_abs_q} * {{nms_pkg::SUM_W{1'b0}}, mult};

    case (p_div_q)
      nms_pkg::DIV3: quot = p_prod_q[nms_pkg::SHIFT_DIV3 +: nms_pkg::MEAN_W];
      nms_pkg::DIV5: quot = p_prod_q[nms_pkg::SHIFT_DIV5 +: nms_pkg::MEAN_W];
      nms_pkg::DIV8: quot = p_prod_q[nms_pkg::SHIFT_DIV8 +: nms_pkg::MEAN_W];
      default:       quot = p_prod_q[nms_pkg::SHIFT_DIV8 +: nms_pkg::MEAN_W];
    endcase
    // truncate toward zero: divide the magnitude, restore the sign, clamp at MEAN_MAX
    if (p_neg_q) begin
      mean_d = -$signed(quot);
    end else if (quot[nms_pkg::MEAN_W-1]) begin
      mean_d = nms_pkg::MEAN_MAX;
    end else begin
      mean_d = $signed(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= emit_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
      if (p_ready) begin
        p_valid_q <= d_valid_q;
      end
      if (o_ready) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready) begin
      c_sum_q <= emit_i.sum;
      c_div_q <= emit_i.div;
      c_tag_q <= emit_i.tag;
    end
    if (d_ready) begin
      d_abs_q <= abs_d;
      d_neg_q <= c_sum_q[nms_pkg::SUM_W-1];
      d_div_q <= c_div_q;
      d_tag_q <= c_tag_q;
    end
    if (p_ready) begin
      p_prod_q <= prod_d;
      p_neg_q  <= d_neg_q;
      p_div_q  <= d_div_q;
      p_tag_q  <= d_tag_q;
    end
    if (o_ready) begin
      o_mean_q <= mean_d;
      o_tag_q  <= p_tag_q;
    end
  end

  assign result_o.valid      = o_valid_q;
  assign result_o.mean_value = o_mean_q;
  assign result_o.out_row    = o_tag_q.row;
  assign result_o.out_col    = o_tag_q.col;
  assign result_o.run_last   = o_tag_q.run_last;
  assign result_o.frame_done = o_tag_q.frame_done;

endmodule

`default_nettype wire

// ===== hw/rtl/neighbour_mean_smoothing_filter.sv =====
// Top level of the neighbour mean smoothing filter: frame counters, size
// registers, input register; uses nms_pkg, nms_if, nms_line_store, nms_window, nms_mean.
//
// sample_i carries one signed 16-bit sample per transaction in raster order.
// result_o carries one smoothed element per transaction: the mean of its
// in-frame 8-neighbours (centre excluded) with 8 fraction bits, truncated
// toward zero, tagged with row and column. run_last marks the last result
// released by a sample, frame_done the frame's final element. A sample
// releases zero to four results, each once its last neighbour has arrived.
// cfg_we_i writes cfg_data_i to register cfg_idx_i (frame rows, frame columns)
// and restarts the frame; write only while idle. Sizes clamp to 2..1024.
// A result passes through the input register, the window stage and the sum,
// magnitude, product and result registers. One sample is taken per cycle while
// each releases at most one result and the receiver keeps up; a sample releasing
// several holds the window stage, handing the mean pipeline one result each ready cycle.
// Reset empties all stages and returns to a 2x2 frame at row 0, column 0; line
// store contents are undefined until written and never reach a result.
// A stalled receiver holds the result register; stages fill back to the input
// and sample_i.ready drops once the input register can not advance.
`default_nettype none

module neighbour_mean_smoothing_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_idx_i,
  input  wire logic [nms_pkg::CFG_W-1:0]     cfg_data_i,
  nms_sample_if.sink                         sample_i,
  nms_result_if.source                       result_o
);

  // frame geometry, stored as last index after clamping
  nms_pkg::idx_t    rows_last_q;
  nms_pkg::idx_t    cols_last_q;
  // position of the next sample
  nms_pkg::idx_t    row_cnt_q;
  nms_pkg::idx_t    col_cnt_q;
  nms_pkg::idx_t    row_cnt_d;
  nms_pkg::idx_t    col_cnt_d;
  nms_pkg::idx_t    cur_row;
  nms_pkg::idx_t    cur_col;

  // input register
  logic             a_valid_q;
  nms_pkg::sample_t a_sample_q;
  nms_pkg::idx_t    a_row_q;
  nms_pkg::idx_t    a_col_q;

  logic             accept;
  logic             item_ready;
  nms_pkg::item_t   item;
  nms_pkg::sample_t rd0;
  nms_pkg::sample_t rd1;
  logic             emit_valid;
  nms_pkg::emit_t   emit;
  logic             emit_ready;

  assign sample_i.ready = !a_valid_q || item_ready;
  assign accept         = sample_i.valid && sample_i.ready;

  always_comb begin
    // restart when the counters lie outside the frame
    if ((row_cnt_q > rows_last_q) || (col_cnt_q > cols_last_q)) begin
      cur_row = '0;
      cur_col = '0;
    end else begin
      cur_row = row_cnt_q;
      cur_col = col_cnt_q;
    end

    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (accept) begin
      if (cur_col == cols_last_q) begin
        col_cnt_d = '0;
        row_cnt_d = (cur_row == rows_last_q) ? '0 : cur_row + nms_pkg::IDX_W'(1);
      end else begin
        col_cnt_d = cur_col + nms_pkg::IDX_W'(1);
        row_cnt_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= nms_pkg::IDX_W'(1);
      cols_last_q <= nms_pkg::IDX_W'(1);
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
      a_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // any write restarts the frame; stored samples stay
        case (cfg_idx_i)
          nms_pkg::CFG_FRAME_ROWS: begin
            rows_last_q <= nms_pkg::size_last(cfg_data_i, nms_pkg::CFG_W'(nms_pkg::MAX_ROWS));
          end
          nms_pkg::CFG_FRAME_COLS: begin
            cols_last_q <= nms_pkg::size_last(cfg_data_i, nms_pkg::CFG_W'(nms_pkg::MAX_COLS));
          end
          default: begin
            rows_last_q <= rows_last_q;
          end
        endcase
        row_cnt_q <= '0;
        col_cnt_q <= '0;
      end else begin
        row_cnt_q <= row_cnt_d;
        col_cnt_q <= col_cnt_d;
      end
      if (sample_i.ready) begin
        a_valid_q <= sample_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sample_q <= sample_i.sample;
      a_row_q    <= cur_row;
      a_col_q    <= cur_col;
    end
  end

  // read both rows above at this column, overwrite the older one
  nms_line_store u_line_store (
    .clk_i     (clk_i),
    .en_i      (accept),
    .addr_i    (cur_col),
    .wr_bank_i (cur_row[0]),
    .wr_data_i (sample_i.sample),
    .rd0_o     (rd0),
    .rd1_o     (rd1)
  );

  // the bank of this row's parity holds the row two above
  always_comb begin
    item.sample = a_sample_q;
    item.above2 = a_row_q[0] ? rd1 : rd0;
    item.above1 = a_row_q[0] ? rd0 : rd1;
    item.row    = a_row_q;
    item.col    = a_col_q;
  end

  nms_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (a_valid_q),
    .item_i       (item),
    .item_ready_o (item_ready),
    .rows_last_i  (rows_last_q),
    .cols_last_i  (cols_last_q),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  nms_mean u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_valid_i (emit_valid),
    .emit_i       (emit),
    .emit_ready_o (emit_ready),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire
